### hdl/rth_pkg.sv
// ----------------------------------------------------------------------------
// rth_pkg: shared types and constants for the RGB to HSV converter
// Holds the pixel and result structs, the divider lane struct and the
// one-bit-per-step restoring division step used by the divider pipeline.
// ----------------------------------------------------------------------------
package rth_pkg;

  // Hue is in 1/64 degree: one 60 degree sector and one full turn.
  localparam int unsigned HUE_SECTOR = 3840;
  localparam int unsigned HUE_TURN   = 23040;
  // Saturation numerator scale: 2 * 65535, the 2 carries the rounding half.
  localparam int unsigned SAT_SCALE2 = 131070;

  // Dividend, divisor and quotient widths of the divider.
  localparam int unsigned DIVIDEND_W = 25;
  localparam int unsigned DIVISOR_W  = 9;
  localparam int unsigned QUOT_W     = 16;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rth_pixel_t;

  typedef struct packed {
    logic [14:0] hue;
    logic [15:0] saturation;
    logic [7:0]  brightness;
  } rth_hsv_t;

  // One division in flight: partial remainder, remaining dividend bits that
  // turn into quotient bits as they shift out, and the divisor.
  typedef struct packed {
    logic [DIVISOR_W-1:0] rem;
    logic [QUOT_W-1:0]    lo;
    logic [DIVISOR_W-1:0] div;
  } rth_lane_t;

  // Everything that travels through the divider stages.
  typedef struct packed {
    rth_lane_t  hue;
    rth_lane_t  sat;
    logic [7:0] bright;
  } rth_div_t;

  // One restoring division step: bring in the next dividend bit, subtract
  // the divisor when it fits and shift the quotient bit in at the bottom.
  function automatic rth_lane_t rth_div_step(rth_lane_t a);
    logic [DIVISOR_W:0] trial;
    logic [DIVISOR_W:0] diff;
    rth_lane_t          r;
    trial = {a.rem, a.lo[QUOT_W-1]};
    diff  = trial - {1'b0, a.div};
    r     = a;
    if (trial >= {1'b0, a.div}) begin
      r.rem = diff[DIVISOR_W-1:0];
      r.lo  = {a.lo[QUOT_W-2:0], 1'b1};
    end else begin
      r.rem = trial[DIVISOR_W-1:0];
      r.lo  = {a.lo[QUOT_W-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

### hdl/rth_div_pipe.sv
// ----------------------------------------------------------------------------
// rth_div_pipe: pipelined dual restoring divider
// Runs the hue and saturation divisions side by side, one quotient bit per
// register stage. Each stage holds its item unless the next one can take it,
// so bubbles close up and a stall loses nothing.
// ----------------------------------------------------------------------------
module rth_div_pipe (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  rth_pkg::rth_div_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output rth_pkg::rth_div_t out_data
);

  localparam int unsigned STAGES = rth_pkg::QUOT_W;

  logic              v_r   [STAGES];
  rth_pkg::rth_div_t d_r   [STAGES];
  logic              src_v [STAGES];
  rth_pkg::rth_div_t src_d [STAGES];
  logic              rdy   [STAGES+1];

  // Stage sources and the ready chain from the output back to the input.
  always_comb begin
    rdy[STAGES] = !out_stall;
    for (int s = STAGES - 1; s >= 0; s--) begin
      rdy[s] = !v_r[s] || rdy[s+1];
    end
    src_v[0] = in_valid;
    src_d[0] = in_data;
    for (int s = 1; s < STAGES; s++) begin
      src_v[s] = v_r[s-1];
      src_d[s] = d_r[s-1];
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < STAGES; s++) v_r[s] <= 1'b0;
    end else begin
      for (int s = 0; s < STAGES; s++) begin
        if (rdy[s]) v_r[s] <= src_v[s];
      end
    end
  end

  // One division step per stage on both lanes.
  always_ff @(posedge clk) begin
    for (int s = 0; s < STAGES; s++) begin
      if (rdy[s]) begin
        d_r[s].hue    <= rth_pkg::rth_div_step(src_d[s].hue);
        d_r[s].sat    <= rth_pkg::rth_div_step(src_d[s].sat);
        d_r[s].bright <= src_d[s].bright;
      end
    end
  end

  assign in_stall  = !rdy[0];
  assign out_valid = v_r[STAGES-1];
  assign out_data  = d_r[STAGES-1];

endmodule

### hdl/rgb_to_hsv_unit.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv_unit: 8-bit RGB to fixed-point HSV converter
// Value is the largest channel, saturation is 65535*d/max and hue is in
// 1/64 degree, both rounded to nearest.
// ----------------------------------------------------------------------------
// The block takes one pixel per clock while the output is not stalled: one
// stage finds the maximum, minimum and sector, one forms the hue and
// saturation dividends, sixteen stages of the divider each produce one
// quotient bit of both divisions, and one stage wraps the hue and holds the
// result. Stalled stages hold their items while empty stages ahead of them
// still fill, so input transfers go on until the pipeline is full.
module rgb_to_hsv_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rth_pkg::rth_pixel_t in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output rth_pkg::rth_hsv_t   out_data
);

  // Sector of the hue, chosen by which channel is largest.
  localparam logic [1:0] SEC_RED      = 2'd0;
  localparam logic [1:0] SEC_RED_WRAP = 2'd1;
  localparam logic [1:0] SEC_GREEN    = 2'd2;
  localparam logic [1:0] SEC_BLUE     = 2'd3;

  localparam int unsigned DW = rth_pkg::DIVIDEND_W;
  localparam int unsigned QW = rth_pkg::QUOT_W;
  localparam int unsigned RW = rth_pkg::DIVISOR_W;

  // Stage A registers: maximum, spread, signed channel difference, sector.
  logic              a_v_r;
  logic [7:0]        a_mx_r, a_mx_nxt;
  logic [7:0]        a_d_r, a_d_nxt;
  logic signed [8:0] a_diff_r, a_diff_nxt;
  logic [1:0]        a_sec_r, a_sec_nxt;

  // Stage B registers: dividends and divisors in divider form.
  logic              b_v_r;
  rth_pkg::rth_div_t b_data_r, b_data_nxt;

  // Output register.
  logic              out_valid_r;
  rth_pkg::rth_hsv_t out_data_r, out_data_nxt;

  logic              div_valid;
  logic              div_stall;
  rth_pkg::rth_div_t div_data;

  logic out_rdy, b_rdy, a_rdy;

  // Ready chain: a stage takes a new item when empty or when it moves on.
  assign out_rdy  = !out_valid_r || !out_stall;
  assign b_rdy    = !b_v_r || !div_stall;
  assign a_rdy    = !a_v_r || b_rdy;
  assign in_stall = !a_rdy;

  // Stage A: max, min, spread and sector with red and then green winning ties.
  always_comb begin
    logic [7:0] mx;
    logic [7:0] mn;
    mx = in_data.red;
    mn = in_data.red;
    if (in_data.green > mx) mx = in_data.green;
    if (in_data.blue > mx) mx = in_data.blue;
    if (in_data.green < mn) mn = in_data.green;
    if (in_data.blue < mn) mn = in_data.blue;
    a_mx_nxt = mx;
    a_d_nxt  = mx - mn;
    if (mx == in_data.red) begin
      a_diff_nxt = $signed({1'b0, in_data.green}) - $signed({1'b0, in_data.blue});
      a_sec_nxt  = (in_data.green < in_data.blue) ? SEC_RED_WRAP : SEC_RED;
    end else if (mx == in_data.green) begin
      a_diff_nxt = $signed({1'b0, in_data.blue}) - $signed({1'b0, in_data.red});
      a_sec_nxt  = SEC_GREEN;
    end else begin
      a_diff_nxt = $signed({1'b0, in_data.red}) - $signed({1'b0, in_data.green});
      a_sec_nxt  = SEC_BLUE;
    end
  end

  // Stage B: hue numerator 3840*diff + offset*d, both dividends with the
  // rounding half folded in. A zero divisor becomes one; its dividend is zero.
  always_comb begin
    logic [14:0]        off;
    logic [22:0]        offd;
    logic signed [24:0] prod;
    logic signed [24:0] num_s;
    logic [DW-1:0]      nh;
    logic [DW-1:0]      ns;
    case (a_sec_r)
      SEC_RED_WRAP: off = 15'(rth_pkg::HUE_TURN);
      SEC_GREEN:    off = 15'(2 * rth_pkg::HUE_SECTOR);
      SEC_BLUE:     off = 15'(4 * rth_pkg::HUE_SECTOR);
      default:      off = 15'd0;
    endcase
    prod  = $signed({{16{a_diff_r[8]}}, a_diff_r}) * $signed(25'(rth_pkg::HUE_SECTOR));
    offd  = 23'(off) * 23'(a_d_r);
    num_s = prod + $signed({2'b00, offd});
    nh    = DW'({num_s[22:0], 1'b0}) + DW'(a_d_r);
    ns    = DW'(rth_pkg::SAT_SCALE2) * DW'(a_d_r) + DW'(a_mx_r);

    b_data_nxt.hue.rem = nh[DW-1:QW];
    b_data_nxt.hue.lo  = nh[QW-1:0];
    b_data_nxt.hue.div = (a_d_r == 8'd0) ? RW'(1) : {a_d_r, 1'b0};
    b_data_nxt.sat.rem = ns[DW-1:QW];
    b_data_nxt.sat.lo  = ns[QW-1:0];
    b_data_nxt.sat.div = (a_mx_r == 8'd0) ? RW'(1) : {a_mx_r, 1'b0};
    b_data_nxt.bright  = a_mx_r;
  end

  // Pipeline valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r       <= 1'b0;
      b_v_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (a_rdy) a_v_r <= in_valid;
      if (b_rdy) b_v_r <= a_v_r;
      if (out_rdy) out_valid_r <= div_valid;
    end
  end

  // Pipeline payload registers.
  always_ff @(posedge clk) begin
    if (a_rdy) begin
      a_mx_r   <= a_mx_nxt;
      a_d_r    <= a_d_nxt;
      a_diff_r <= a_diff_nxt;
      a_sec_r  <= a_sec_nxt;
    end
    if (b_rdy) b_data_r <= b_data_nxt;
    if (out_rdy) out_data_r <= out_data_nxt;
  end

  rth_div_pipe u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (b_v_r),
    .in_stall  (div_stall),
    .in_data   (b_data_r),
    .out_valid (div_valid),
    .out_stall (!out_rdy),
    .out_data  (div_data)
  );

  // Output stage: a rounded hue of a full turn wraps to zero.
  always_comb begin
    logic [QW-1:0] q;
    q = div_data.hue.lo;
    if (q >= QW'(rth_pkg::HUE_TURN)) begin
      out_data_nxt.hue = 15'(q - QW'(rth_pkg::HUE_TURN));
    end else begin
      out_data_nxt.hue = q[14:0];
    end
    out_data_nxt.saturation = div_data.sat.lo;
    out_data_nxt.brightness = div_data.bright;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### hdl/rth_checker.sv
// ----------------------------------------------------------------------------
// rth_checker: port-level checks for the RGB to HSV converter
// Watches the result channel for a held transfer and for value relations
// that every converted pixel must keep.
// ----------------------------------------------------------------------------
module rth_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input rth_pkg::rth_hsv_t   out_data
);

  // A stalled result stays offered unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // Hue always lies below a full turn.
  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.hue < 15'd23040)
    else $error("hue out of range");

  // A black pixel has neither saturation nor hue.
  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.brightness == 8'd0 |->
      out_data.saturation == 16'd0 && out_data.hue == 15'd0)
    else $error("black pixel with saturation or hue");

  // Zero saturation only comes from a gray pixel, whose hue is zero.
  a_gray: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.saturation == 16'd0 |-> out_data.hue == 15'd0)
    else $error("gray pixel with nonzero hue");

  // Reset empties the result channel.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered right after reset");

endmodule

bind rgb_to_hsv_unit rth_checker u_rth_checker (.*);
